### hw/rtl/gbc_pkg.sv
// Shared constants, control struct and helpers for the gyro bias calibration block.
package gbc_pkg;

  localparam int WIN_LG    = 10;
  localparam int WINDOW    = 1 << WIN_LG;
  localparam int GUARD     = 10;
  localparam int CNT_W     = $clog2(WINDOW + GUARD + 2);
  localparam int SUM_W     = 28;
  localparam int DEV_W     = SUM_W;
  localparam int DEV_SUM_W = DEV_W + 2;
  localparam int FRAC_W    = 14;
  localparam int PROD_W    = 34;
  localparam int ONE_Q14   = 1 << FRAC_W;
  localparam int SCALE_TOL = 1638;
  localparam int IDX_W     = 4;

  localparam logic [15:0] ONE_SCALE = 16'(ONE_Q14);
  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1 << (FRAC_W - 1));

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_MODE     = 4'd0;
  localparam logic [IDX_W-1:0] REG_OFFSET_X = 4'd1;
  localparam logic [IDX_W-1:0] REG_OFFSET_Y = 4'd2;
  localparam logic [IDX_W-1:0] REG_OFFSET_Z = 4'd3;
  localparam logic [IDX_W-1:0] REG_SCALE_X  = 4'd4;
  localparam logic [IDX_W-1:0] REG_SCALE_Y  = 4'd5;
  localparam logic [IDX_W-1:0] REG_SCALE_Z  = 4'd6;
  localparam logic [IDX_W-1:0] REG_THRESH   = 4'd7;

  typedef struct packed {
    logic accum;   // sample feeds the window
    logic done;    // sample completes a window
    logic adopt;   // window passed, take the averages
    logic clear;   // clear the per-axis sums
  } gbc_ctl_t;

  function automatic logic scale_in_range(input logic [15:0] s);
    return (s >= 16'(ONE_Q14 - SCALE_TOL)) && (s <= 16'(ONE_Q14 + SCALE_TOL));
  endfunction

endpackage

### hw/rtl/gbc_lane.sv
// One axis lane: active offset and scale, window sum, deviation and correction pipe.
module gbc_lane import gbc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  logic               out_load,
  input  gbc_ctl_t           ctl,
  input  logic signed [15:0] raw,
  input  logic               load_en,
  input  logic signed [15:0] load_offset,
  input  logic [15:0]        load_scale,
  output logic [DEV_W-1:0]   dev,
  output logic signed [15:0] rate,
  output logic signed [15:0] bias
);

  logic signed [15:0]       offset;
  logic [15:0]              scale;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sum_next;
  logic signed [SUM_W-1:0]  avg_full;
  logic signed [SUM_W:0]    raw_win;
  logic signed [SUM_W:0]    dev_diff;
  logic signed [SUM_W:0]    dev_neg;
  logic signed [15:0]       offset_next;
  logic [15:0]              scale_next;
  logic signed [16:0]       diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] rnd;
  logic signed [PROD_W-1:0] quo;
  logic signed [15:0]       s1_bias;
  logic signed [15:0]       sat;

  // Window sum including this sample, and its deviation from raw * WINDOW
  assign sum_next = sum + {{(SUM_W-16){raw[15]}}, raw};
  assign raw_win  = {{(SUM_W+1-16-WIN_LG){raw[15]}}, raw, {WIN_LG{1'b0}}};
  assign dev_diff = raw_win - {sum_next[SUM_W-1], sum_next};
  assign dev_neg  = -dev_diff;
  assign dev      = dev_diff[SUM_W] ? dev_neg[DEV_W-1:0] : dev_diff[DEV_W-1:0];

  // Rounded average, ties toward +inf
  assign avg_full    = sum_next + SUM_W'(WINDOW / 2);
  assign offset_next = ctl.adopt ? avg_full[WIN_LG +: 16] : offset;
  assign scale_next  = ctl.adopt ? ONE_SCALE : scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
      scale  <= ONE_SCALE;
      sum    <= '0;
    end else if (load_en) begin
      offset <= load_offset;
      scale  <= load_scale;
    end else if (in_fire) begin
      offset <= offset_next;
      scale  <= scale_next;
      if (ctl.accum) begin
        sum <= ctl.clear ? '0 : sum_next;
      end
    end
  end

  // Correction, stage one: multiply with the offset and scale in force before this beat
  assign diff = {raw[15], raw} - {offset[15], offset};
  assign prod = diff * $signed({1'b0, scale});

  always_ff @(posedge clk) begin
    if (in_fire) begin
      prod_q  <= prod;
      s1_bias <= offset_next;
    end
  end

  // Stage two: round and saturate
  assign rnd = prod_q + RND_HALF;
  assign quo = rnd >>> FRAC_W;

  always_comb begin
    if (quo > PROD_W'(32767)) begin
      sat = 16'sh7FFF;
    end else if (quo < -PROD_W'(32768)) begin
      sat = -16'sh8000;
    end else begin
      sat = quo[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rate <= sat;
      bias <= s1_bias;
    end
  end

endmodule

### hw/rtl/gbc_merge.sv
// Merge stage: total deviation test, window count and calibration decisions.
module gbc_merge import gbc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_fire,
  input  logic             mode,
  input  logic             is_still,
  input  logic [DEV_W-1:0] dev [3],
  input  logic [15:0]      thr,
  output gbc_ctl_t         ctl,
  output logic [CNT_W-1:0] count
);

  logic [DEV_SUM_W-1:0] total;
  logic [DEV_SUM_W-1:0] limit;
  logic [CNT_W-1:0]     cnt_inc;
  logic                 guard_hit;

  assign total   = DEV_SUM_W'(dev[0]) + DEV_SUM_W'(dev[1]) + DEV_SUM_W'(dev[2]);
  assign limit   = DEV_SUM_W'(thr) << WIN_LG;
  assign cnt_inc = count + CNT_W'(1);

  always_comb begin
    ctl.accum = mode & is_still;
    ctl.done  = ctl.accum && (cnt_inc == CNT_W'(WINDOW));
    ctl.adopt = ctl.done && (total < limit);
    guard_hit = ctl.accum && !ctl.adopt && (cnt_inc > CNT_W'(WINDOW + GUARD));
    ctl.clear = ctl.done || guard_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_fire && ctl.accum) begin
      count <= (ctl.adopt || guard_hit) ? '0 : cnt_inc;
    end
  end

endmodule

### hw/rtl/gyro_bias_calibration_correction.sv
// Top level of the gyro zero-rate bias calibration and correction block.
// Each beat carries one three-axis raw sample and a stillness flag and yields
// exactly one result beat: the corrected rates ((raw - offset) * scale, scale
// in unsigned Q2.14, rounded half up and saturated to 16 bits), the window
// flags and the active offsets after the beat. Three axis lanes work side by
// side; a merge stage sums their deviations and decides whether a completed
// window of 1024 still samples is adopted. The block takes one beat per cycle
// while the output is not stalled. The first stage updates the window sums and
// the offsets and registers the 17x17 product; the second rounds and saturates
// it into the output register. A stalled output holds one beat in the output
// register and one in the product stage before in_stall rises. Configuration
// writes are always ready and reload the active offsets and scales in the
// same edge; if any stored scale lies outside 0.9..1.1 all scales load as 1.0.
module gyro_bias_calibration_correction import gbc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] raw_x,
  input  logic signed [15:0] raw_y,
  input  logic signed [15:0] raw_z,
  input  logic               is_still,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] rate_x,
  output logic signed [15:0] rate_y,
  output logic signed [15:0] rate_z,
  output logic               window_done,
  output logic               cal_success,
  output logic signed [15:0] bias_x,
  output logic signed [15:0] bias_y,
  output logic signed [15:0] bias_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [15:0]        cfg_data
);

  // Stored configuration
  logic               calibrate_mode;
  logic signed [15:0] stored_offset [3];
  logic [15:0]        stored_scale [3];
  logic [15:0]        still_threshold;

  logic               calibrate_mode_next;
  logic signed [15:0] stored_offset_next [3];
  logic [15:0]        stored_scale_next [3];
  logic [15:0]        still_threshold_next;

  logic               cfg_fire;
  logic               reload;
  logic               scales_ok;
  logic [15:0]        load_scale [3];

  // Handshake and pipeline control
  logic               in_fire;
  logic               s1_valid;
  logic               out_load;
  logic               out_fire;
  logic               s1_done;
  logic               s1_ok;

  logic signed [15:0] raw [3];
  logic [DEV_W-1:0]   dev [3];
  logic signed [15:0] rate [3];
  logic signed [15:0] bias [3];
  gbc_ctl_t           ctl;
  logic [CNT_W-1:0]   count;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;

  // Decode a write into next values so the reload sees the new register
  always_comb begin
    calibrate_mode_next  = calibrate_mode;
    still_threshold_next = still_threshold;
    for (int i = 0; i < 3; i++) begin
      stored_offset_next[i] = stored_offset[i];
      stored_scale_next[i]  = stored_scale[i];
    end
    reload = 1'b0;
    if (cfg_fire) begin
      reload = 1'b1;
      case (cfg_index)
        REG_MODE:     calibrate_mode_next   = cfg_data[0];
        REG_OFFSET_X: stored_offset_next[0] = cfg_data;
        REG_OFFSET_Y: stored_offset_next[1] = cfg_data;
        REG_OFFSET_Z: stored_offset_next[2] = cfg_data;
        REG_SCALE_X:  stored_scale_next[0]  = cfg_data;
        REG_SCALE_Y:  stored_scale_next[1]  = cfg_data;
        REG_SCALE_Z:  stored_scale_next[2]  = cfg_data;
        REG_THRESH:   still_threshold_next  = cfg_data;
        default:      reload = 1'b0;  // drop writes to unknown indexes
      endcase
    end
  end

  // One out-of-range scale forces all three to unity
  assign scales_ok = scale_in_range(stored_scale_next[0]) &&
                     scale_in_range(stored_scale_next[1]) &&
                     scale_in_range(stored_scale_next[2]);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      load_scale[i] = scales_ok ? stored_scale_next[i] : ONE_SCALE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      calibrate_mode  <= 1'b0;
      still_threshold <= 16'd20;
      for (int i = 0; i < 3; i++) begin
        stored_offset[i] <= '0;
        stored_scale[i]  <= ONE_SCALE;
      end
    end else begin
      calibrate_mode  <= calibrate_mode_next;
      still_threshold <= still_threshold_next;
      for (int i = 0; i < 3; i++) begin
        stored_offset[i] <= stored_offset_next[i];
        stored_scale[i]  <= stored_scale_next[i];
      end
    end
  end

  // Two-stage pipe: the product stage advances when empty or when it moves on
  assign out_fire = out_valid && !out_stall;
  assign out_load = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !out_load;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (out_load) begin
        s1_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Window flags travel with the beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_done <= ctl.done;
      s1_ok   <= ctl.adopt;
    end
    if (out_load) begin
      window_done <= s1_done;
      cal_success <= s1_ok;
    end
  end

  assign raw[0] = raw_x;
  assign raw[1] = raw_y;
  assign raw[2] = raw_z;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    gbc_lane u_lane (
      .clk         (clk),
      .rst         (rst),
      .in_fire     (in_fire),
      .out_load    (out_load),
      .ctl         (ctl),
      .raw         (raw[g]),
      .load_en     (reload),
      .load_offset (stored_offset_next[g]),
      .load_scale  (load_scale[g]),
      .dev         (dev[g]),
      .rate        (rate[g]),
      .bias        (bias[g])
    );
  end

  gbc_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .mode     (calibrate_mode),
    .is_still (is_still),
    .dev      (dev),
    .thr      (still_threshold),
    .ctl      (ctl),
    .count    (count)
  );

  assign rate_x = rate[0];
  assign rate_y = rate[1];
  assign rate_z = rate[2];
  assign bias_x = bias[0];
  assign bias_y = bias[1];
  assign bias_z = bias[2];

  // Adoption only ever comes with a completed window
  a_success_needs_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && cal_success |-> window_done)
    else $error("cal_success without window_done");

  // An empty product stage never pushes back on the input
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("input stalled with empty product stage");

  // The guard keeps the window count bounded
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(WINDOW + GUARD))
    else $error("window count past guard");

  // An adopted window restarts the count
  a_adopt_clears_count: assert property (@(posedge clk) disable iff (rst)
    in_fire && ctl.adopt |=> count == '0)
    else $error("count not cleared after adoption");

endmodule
